// ===== rtl/core/protobuf_read_reply_decoder_top_assert.svh =====
// Assertion macros for the read reply decoder.
// Each use sits on a line of its own, inside a module that has clk and arst_n.
`ifndef PROTOBUF_READ_REPLY_DECODER_TOP_ASSERT_SVH
`define PROTOBUF_READ_REPLY_DECODER_TOP_ASSERT_SVH
`ifndef SYNTH
// Check a property on every clock edge out of reset.
`define RRD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define RRD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RRD_ASSERT(lbl, prop, msg)
`define RRD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/rrd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rrd_pkg;

	// Sizes
	localparam int VALUE_MAX   = 32;
	localparam int MESSAGE_MAX = 4096;

	localparam int DATA_W    = 8;
	localparam int STATUS_W  = 2;
	localparam int WORD_W    = 32;
	localparam int LENGTH_W  = 6;
	localparam int INDEX_W   = 5;
	localparam int ACC_W     = 64;
	localparam int GROUP_W   = 7;
	localparam int CNT_W     = 4;
	localparam int VARINT_MAX_BYTES = 10;
	localparam int TAG_SHIFT = 3;

	localparam int KW = $clog2(VALUE_MAX + 1);
	localparam int IW = $clog2(VALUE_MAX);
	localparam int AW = $clog2(2 * VALUE_MAX);
	localparam int BW = $clog2(MESSAGE_MAX);

	// Field classes
	localparam logic [1:0] FC_OTHER    = 2'd0;
	localparam logic [1:0] FC_ERROR    = 2'd1;
	localparam logic [1:0] FC_THROTTLE = 2'd2;
	localparam logic [1:0] FC_VALUE    = 2'd3;

	// Wire types
	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_LEN    = 3'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_FAILED = 2'd3;
	localparam logic [WORD_W-1:0] ERR_LAST_KNOWN = 32'd2;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_VALUE,
		PH_LEN,
		PH_PAYLOAD,
		PH_DRAIN,
		PH_STOPPED
	} phase_t;

	// Message summary handed over on the final byte
	typedef struct packed {
		logic                valid;
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   throttle;
		logic                present;
		logic [KW-1:0]       len;
		logic                bank;
		logic                too_long;
		logic                stopped;
	} snap_t;

	// Value store write port
	typedef struct packed {
		logic              en;
		logic              bank;
		logic [AW-1:0]     addr;
		logic [DATA_W-1:0] data;
	} store_wr_t;

	// Readout status seen by the parser
	typedef struct packed {
		logic free;
		logic bank;
	} emit_stat_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status_code;
		logic [WORD_W-1:0]   throttle_ms;
		logic                value_present;
		logic [LENGTH_W-1:0] value_length;
		logic [DATA_W-1:0]   value_byte;
		logic [INDEX_W-1:0]  byte_index;
		logic                value_too_long;
		logic                stopped_early;
		logic                last_result;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/core/rrd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Byte stream channel
interface rrd_byte_if import rrd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

// Result channel
interface rrd_result_if import rrd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status_code;
	logic [WORD_W-1:0]   throttle_ms;
	logic                value_present;
	logic [LENGTH_W-1:0] value_length;
	logic [DATA_W-1:0]   value_byte;
	logic [INDEX_W-1:0]  byte_index;
	logic                value_too_long;
	logic                stopped_early;
	logic                last_result;

	modport source (output valid, output status_code, output throttle_ms,
		output value_present, output value_length, output value_byte,
		output byte_index, output value_too_long, output stopped_early,
		output last_result, input ready);
	modport sink (input valid, input status_code, input throttle_ms,
		input value_present, input value_length, input value_byte,
		input byte_index, input value_too_long, input stopped_early,
		input last_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rrd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rrd_parser import rrd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rrd_byte_if.sink    rx,
	input  emit_stat_t  stat,
	output store_wr_t   wr,
	output snap_t       snap
);

	phase_t              phase_q, phase_n;
	logic [ACC_W-1:0]    accum_q, accum_n, accum_v;
	logic [CNT_W-1:0]    cnt_q, cnt_n, cnt_inc;
	logic [1:0]          class_q, class_n;
	logic [BW-1:0]       left_q, left_n;
	logic                fits_q, fits_n;
	logic [KW-1:0]       len_q, len_n;
	logic                bank_q, bank_n;
	logic [KW-1:0]       clen_q, clen_n;
	logic [WORD_W-1:0]   err_q, err_n;
	logic [WORD_W-1:0]   thr_q, thr_n;
	logic                present_q, present_n;
	logic                long_q, long_n;
	logic                stop_q, stop_n;

	logic                fin_commit, fin_drop;
	logic [KW-1:0]       fin_len;
	logic [WORD_W-1:0]   fnum;
	logic [2:0]          wtype;
	logic                wr_req;
	logic [AW-1:0]       wr_addr;
	logic [KW-1:0]       idx;
	logic                accept;

	// Hold the byte while readout still needs the summary or the bank it would overwrite
	assign rx.ready = stat.free || !(rx.end_of_message || (wr_req && (!bank_q == stat.bank)));
	assign accept = rx.valid && rx.ready;

	// Fold the byte into the varint, seven bits per byte, one bit from the tenth
	always_comb begin
		accum_v = (cnt_q == '0) ? '0 : accum_q;
		for (int i = 0; i < VARINT_MAX_BYTES - 1; i++) begin
			if (cnt_q == CNT_W'(i)) begin
				accum_v[GROUP_W*i +: GROUP_W] = rx.data_byte[GROUP_W-1:0];
			end
		end
		if (cnt_q == CNT_W'(VARINT_MAX_BYTES - 1)) begin
			accum_v[ACC_W-1] = rx.data_byte[0];
		end
	end

	assign cnt_inc = cnt_q + CNT_W'(1);
	assign fnum    = accum_v[TAG_SHIFT +: WORD_W];
	assign wtype   = accum_v[2:0];
	assign idx     = len_q - KW'(left_q);
	assign wr_addr = AW'(idx) + (bank_q ? AW'(0) : AW'(VALUE_MAX));
	assign wr_req  = (phase_q == PH_PAYLOAD) && fits_q;

	// Next parse state
	always_comb begin
		phase_n    = phase_q;
		accum_n    = accum_q;
		cnt_n      = cnt_q;
		class_n    = class_q;
		left_n     = left_q;
		fits_n     = fits_q;
		len_n      = len_q;
		err_n      = err_q;
		thr_n      = thr_q;
		stop_n     = stop_q;
		fin_commit = 1'b0;
		fin_drop   = 1'b0;
		fin_len    = len_q;
		case (phase_q)
			PH_TAG, PH_VALUE, PH_LEN: begin
				accum_n = accum_v;
				if (!rx.data_byte[DATA_W-1]) begin
					cnt_n = '0;
					case (phase_q)
						PH_TAG: begin
							class_n = (fnum inside {[32'd1:32'd3]}) ? fnum[1:0] : FC_OTHER;
							if (wtype == WT_VARINT) begin
								phase_n = PH_VALUE;
							end else if (wtype == WT_LEN) begin
								phase_n = PH_LEN;
							end else begin
								phase_n = PH_STOPPED;
								stop_n  = 1'b1;
							end
						end
						PH_VALUE: begin
							if (class_q == FC_ERROR) begin
								err_n = accum_v[WORD_W-1:0];
							end else if (class_q == FC_THROTTLE) begin
								thr_n = accum_v[WORD_W-1:0];
							end
							phase_n = PH_TAG;
						end
						default: begin
							if (accum_v == '0) begin
								fin_commit = (class_q == FC_VALUE);
								fin_len    = '0;
								phase_n    = PH_TAG;
							end else if (accum_v >= ACC_W'(MESSAGE_MAX)) begin
								phase_n = PH_DRAIN;
							end else begin
								left_n  = accum_v[BW-1:0];
								fits_n  = (class_q == FC_VALUE) && (accum_v <= ACC_W'(VALUE_MAX));
								len_n   = accum_v[KW-1:0];
								phase_n = PH_PAYLOAD;
							end
						end
					endcase
				end else if (cnt_inc >= CNT_W'(VARINT_MAX_BYTES)) begin
					cnt_n   = '0;
					phase_n = PH_STOPPED;
					stop_n  = 1'b1;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			PH_PAYLOAD: begin
				left_n = left_q - BW'(1);
				if (left_q == BW'(1)) begin
					fin_commit = fits_q;
					fin_drop   = (class_q == FC_VALUE) && !fits_q;
					phase_n    = PH_TAG;
				end
			end
			default: begin
			end
		endcase
	end

	// Commit or drop a finished field 3 payload
	always_comb begin
		bank_n    = bank_q;
		clen_n    = clen_q;
		present_n = present_q;
		long_n    = long_q;
		if (fin_commit) begin
			bank_n    = !bank_q;
			clen_n    = fin_len;
			present_n = 1'b1;
			long_n    = 1'b0;
		end else if (fin_drop) begin
			clen_n    = '0;
			present_n = 1'b0;
			long_n    = 1'b1;
		end
	end

	// Drive the store write and the message summary
	always_comb begin
		wr.en         = accept && wr_req;
		wr.bank       = !bank_q;
		wr.addr       = wr_addr;
		wr.data       = rx.data_byte;
		snap.valid    = accept && rx.end_of_message;
		snap.status   = (err_n <= ERR_LAST_KNOWN) ? err_n[STATUS_W-1:0] : ST_FAILED;
		snap.throttle = thr_n;
		snap.present  = present_n;
		snap.len      = clen_n;
		snap.bank     = bank_n;
		snap.too_long = long_n;
		snap.stopped  = stop_n;
	end

	// Advance on each accepted beat; start over after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TAG;
			accum_q   <= '0;
			cnt_q     <= '0;
			class_q   <= FC_OTHER;
			left_q    <= '0;
			fits_q    <= 1'b0;
			len_q     <= '0;
			bank_q    <= 1'b0;
			clen_q    <= '0;
			err_q     <= '0;
			thr_q     <= '0;
			present_q <= 1'b0;
			long_q    <= 1'b0;
			stop_q    <= 1'b0;
		end else if (accept) begin
			bank_q <= bank_n;
			if (rx.end_of_message) begin
				phase_q   <= PH_TAG;
				accum_q   <= '0;
				cnt_q     <= '0;
				class_q   <= FC_OTHER;
				left_q    <= '0;
				fits_q    <= 1'b0;
				len_q     <= '0;
				clen_q    <= '0;
				err_q     <= '0;
				thr_q     <= '0;
				present_q <= 1'b0;
				long_q    <= 1'b0;
				stop_q    <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				accum_q   <= accum_n;
				cnt_q     <= cnt_n;
				class_q   <= class_n;
				left_q    <= left_n;
				fits_q    <= fits_n;
				len_q     <= len_n;
				clen_q    <= clen_n;
				err_q     <= err_n;
				thr_q     <= thr_n;
				present_q <= present_n;
				long_q    <= long_n;
				stop_q    <= stop_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/rrd_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "protobuf_read_reply_decoder_top_assert.svh"
module rrd_emit import rrd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  store_wr_t    wr,
	input  snap_t        snap,
	output emit_stat_t   stat,
	rrd_result_if.source tx
);

	// Two banks of value bytes: one being filled, one committed
	logic [DATA_W-1:0] mem [2*VALUE_MAX];

	logic                busy_q;
	logic [KW-1:0]       k_q;
	logic [KW-1:0]       count_q;
	logic                bank_q;
	logic [KW-1:0]       len_q;
	logic                present_q;
	logic [STATUS_W-1:0] status_q;
	logic [WORD_W-1:0]   thr_q;
	logic                long_q;
	logic                stop_q;

	logic                s1_v_q;
	result_t             meta_s1;
	logic                zero_s1;
	logic [DATA_W-1:0]   rdata_s1;
	logic                out_v_q;
	result_t             out_q;

	logic                s1_move, rd_en, last_item;
	logic [AW-1:0]       raddr;
	result_t             meta_n;
	result_t             out_n;

	assign s1_move   = s1_v_q && (!out_v_q || tx.ready);
	assign rd_en     = busy_q && (!s1_v_q || s1_move);
	assign last_item = (KW'(k_q + KW'(1)) == count_q);
	assign raddr     = AW'(k_q) + (bank_q ? AW'(VALUE_MAX) : AW'(0));

	assign stat.free = !busy_q || (rd_en && last_item);
	assign stat.bank = bank_q;

	// Build the fields of the result being read
	always_comb begin
		meta_n.status_code    = status_q;
		meta_n.throttle_ms    = thr_q;
		meta_n.value_present  = present_q;
		meta_n.value_length   = present_q ? LENGTH_W'(len_q) : '0;
		meta_n.value_byte     = '0;
		meta_n.byte_index     = (present_q && len_q != '0) ? INDEX_W'(k_q) : '0;
		meta_n.value_too_long = long_q;
		meta_n.stopped_early  = stop_q;
		meta_n.last_result    = last_item;
	end

	// Store: write from the parser, registered read for the readout
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// Run control: load a summary, step through its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (snap.valid) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (rd_en) begin
			if (last_item) begin
				busy_q <= 1'b0;
			end
			k_q <= k_q + KW'(1);
		end
	end

	// Hold the summary of the run
	always_ff @(posedge clk) begin
		if (snap.valid) begin
			bank_q    <= snap.bank;
			len_q     <= snap.len;
			present_q <= snap.present;
			count_q   <= (snap.present && snap.len != '0) ? snap.len : KW'(1);
			status_q  <= snap.status;
			thr_q     <= snap.throttle;
			long_q    <= snap.too_long;
			stop_q    <= snap.stopped;
		end
	end

	// Read stage and output register valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rd_en) begin
				s1_v_q <= 1'b1;
			end else if (s1_move) begin
				s1_v_q <= 1'b0;
			end
			if (s1_move) begin
				out_v_q <= 1'b1;
			end else if (tx.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Merge the store byte into the result fields
	always_comb begin
		out_n            = meta_s1;
		out_n.value_byte = zero_s1 ? '0 : rdata_s1;
	end

	// Advance payload through the read stage into the output register
	always_ff @(posedge clk) begin
		if (rd_en) begin
			meta_s1 <= meta_n;
			zero_s1 <= !(present_q && k_q < len_q);
		end
		if (s1_move) begin
			out_q <= out_n;
		end
	end

	assign tx.valid          = out_v_q;
	assign tx.status_code    = out_q.status_code;
	assign tx.throttle_ms    = out_q.throttle_ms;
	assign tx.value_present  = out_q.value_present;
	assign tx.value_length   = out_q.value_length;
	assign tx.value_byte     = out_q.value_byte;
	assign tx.byte_index     = out_q.byte_index;
	assign tx.value_too_long = out_q.value_too_long;
	assign tx.stopped_early  = out_q.stopped_early;
	assign tx.last_result    = out_q.last_result;

	`RRD_ASSERT(a_snap_when_free, snap.valid |-> stat.free, "summary loaded while run still reading")
	`RRD_ASSERT(a_no_bank_clash, (wr.en && busy_q && !(rd_en && last_item)) |-> (wr.bank != bank_q), "write into bank under readout")
	`RRD_ASSERT(a_run_ends, (rd_en && last_item && !snap.valid) |=> !busy_q, "run kept going past its last result")
	`RRD_ASSERT(a_count_bound, busy_q |-> (k_q < count_q), "result counter ran past run length")

endmodule
`default_nettype wire

// ===== rtl/core/protobuf_read_reply_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Role     Beat
// bytes     sink     one reply byte, end_of_message on the final one
// results   source   one result per value byte, at least one per message
//
// A byte is taken each cycle that ready is high; field decoding finishes in the
// cycle of its byte. After its final byte, the results of a message pass the run
// control, store read stage and output register, one per cycle while accepted.
// A final byte, or a field 3 payload byte aimed at the bank still being read,
// waits until the readout has issued its last store read.
// Reset clears parser and readout control; the value store holds no reset state.
module protobuf_read_reply_decoder_top import rrd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rrd_byte_if.sink     bytes,
	rrd_result_if.source results
);

	emit_stat_t stat;
	store_wr_t  wr;
	snap_t      snap;

	rrd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (bytes),
		.stat   (stat),
		.wr     (wr),
		.snap   (snap)
	);

	rrd_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.snap   (snap),
		.stat   (stat),
		.tx     (results)
	);

endmodule
`default_nettype wire

// ===== bench/protobuf_read_reply_decoder_top_test.sv =====
`timescale 1ns / 1ps
module protobuf_read_reply_decoder_top_test;
	import rrd_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int ITEMS          = 120;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 16;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_KEY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_THROTTLE = 2'd2;

	typedef struct {
		logic [DATA_W-1:0] data;
		logic              eom;
		bit                typed;
		result_t           res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	rrd_byte_if   byte_ch ();
	rrd_result_if res_ch ();

	protobuf_read_reply_decoder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.results (res_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Decoder shadow state
	phase_t              pr_phase;
	logic [ACC_W-1:0]    pr_acc;
	int                  pr_nbytes;
	logic [1:0]          pr_class;
	int                  pr_left;
	logic [DATA_W-1:0]   value_mem [2 * VALUE_MAX];
	logic                pr_bank;
	int                  pr_len;
	logic [WORD_W-1:0]   pr_err;
	logic [WORD_W-1:0]   pr_thr;
	logic                pr_present;
	logic                pr_long;
	logic                pr_stop;

	result_t           pending_results [$];
	result_t           beat_results [$];
	stim_row_t         directed_tab [$];
	logic [DATA_W-1:0] msg_q [$];

	int mismatches;
	int live_beats;
	int idle_cycles;
	bit no_idle;
	bit hold_req;

	// Clear the per-message state
	task automatic clear_message();
		pr_phase   = PH_TAG;
		pr_acc     = '0;
		pr_nbytes  = 0;
		pr_class   = FC_OTHER;
		pr_left    = 0;
		pr_len     = 0;
		pr_err     = '0;
		pr_thr     = '0;
		pr_present = 1'b0;
		pr_long    = 1'b0;
		pr_stop    = 1'b0;
	endtask

	// Close a length-delimited payload; field 3 commits or flags the value
	task automatic close_payload();
		if (pr_class == FC_VALUE) begin
			if (pr_acc <= VALUE_MAX) begin
				pr_bank    = ~pr_bank;
				pr_len     = int'(pr_acc);
				pr_present = 1'b1;
				pr_long    = 1'b0;
			end else begin
				pr_long    = 1'b1;
				pr_present = 1'b0;
				pr_len     = 0;
			end
		end
		pr_phase = PH_TAG;
	endtask

	// Act on a completed varint according to the current phase
	task automatic close_varint();
		logic [WORD_W-1:0] fnum;
		case (pr_phase)
			PH_TAG: begin
				fnum = WORD_W'(pr_acc >> TAG_SHIFT);
				pr_class = (fnum >= 1 && fnum <= 3) ? fnum[1:0] : FC_OTHER;
				if (pr_acc[2:0] == WT_VARINT) pr_phase = PH_VALUE;
				else if (pr_acc[2:0] == WT_LEN) pr_phase = PH_LEN;
				else begin
					pr_phase = PH_STOPPED;
					pr_stop  = 1'b1;
				end
			end
			PH_VALUE: begin
				if (pr_class == FC_ERROR) pr_err = pr_acc[WORD_W-1:0];
				else if (pr_class == FC_THROTTLE) pr_thr = pr_acc[WORD_W-1:0];
				pr_phase = PH_TAG;
			end
			default: begin
				if (pr_acc == 0) close_payload();
				else if (pr_acc >= MESSAGE_MAX) pr_phase = PH_DRAIN;
				else begin
					pr_left  = int'(pr_acc);
					pr_phase = PH_PAYLOAD;
				end
			end
		endcase
	endtask

	// Advance the decoder by one byte; on the end mark, emit the message results
	task automatic decode_byte(input logic [DATA_W-1:0] b, input logic eom);
		int sh;
		int count;
		logic [STATUS_W-1:0] st;
		result_t r;
		if (eom || (pr_phase != PH_DRAIN && pr_phase != PH_STOPPED)) live_beats++;
		if (pr_phase == PH_TAG || pr_phase == PH_VALUE || pr_phase == PH_LEN) begin
			sh = GROUP_W * pr_nbytes;
			if (pr_nbytes == 0) pr_acc = '0;
			if (sh < ACC_W) pr_acc = pr_acc | (ACC_W'(b[6:0]) << sh);
			pr_nbytes++;
			if (!b[7]) begin
				pr_nbytes = 0;
				close_varint();
			end else if (pr_nbytes >= VARINT_MAX_BYTES) begin
				pr_nbytes = 0;
				pr_phase  = PH_STOPPED;
				pr_stop   = 1'b1;
			end
		end else if (pr_phase == PH_PAYLOAD) begin
			// fill the bank that is not committed
			if (pr_class == FC_VALUE && pr_acc <= VALUE_MAX)
				value_mem[(pr_bank ? 0 : VALUE_MAX) + int'(pr_acc) - pr_left] = b;
			pr_left--;
			if (pr_left == 0) close_payload();
		end
		if (eom) begin
			st = (pr_err <= ERR_LAST_KNOWN) ? pr_err[STATUS_W-1:0] : ST_FAILED;
			count = (pr_present && pr_len > 0) ? pr_len : 1;
			for (int k = 0; k < count; k++) begin
				r.status_code    = st;
				r.throttle_ms    = pr_thr;
				r.value_present  = pr_present;
				r.value_length   = pr_present ? LENGTH_W'(pr_len) : '0;
				r.value_byte     = (pr_present && k < pr_len) ?
					value_mem[(pr_bank ? VALUE_MAX : 0) + k] : '0;
				r.byte_index     = (pr_present && pr_len > 0) ? INDEX_W'(k) : '0;
				r.value_too_long = pr_long;
				r.stopped_early  = pr_stop;
				r.last_result    = (k + 1 == count);
				beat_results.push_back(r);
			end
			clear_message();
		end
	endtask

	// Single-result message with no value bytes
	function automatic result_t single_result(input logic [STATUS_W-1:0] st,
			input logic [WORD_W-1:0] thr, input logic present, input logic stop);
		result_t r;
		r = '0;
		r.status_code   = st;
		r.throttle_ms   = thr;
		r.value_present = present;
		r.stopped_early = stop;
		r.last_result   = 1'b1;
		return r;
	endfunction

	task automatic add_row(input logic [DATA_W-1:0] data, input logic eom);
		stim_row_t row;
		row.data  = data;
		row.eom   = eom;
		row.typed = 1'b0;
		row.res   = '0;
		directed_tab.push_back(row);
	endtask

	task automatic add_checked(input logic [DATA_W-1:0] data, input result_t res);
		stim_row_t row;
		row.data  = data;
		row.eom   = 1'b1;
		row.typed = 1'b1;
		row.res   = res;
		directed_tab.push_back(row);
	endtask

	task automatic build_directed();
		// lone tag on the end mark: nothing decoded
		add_checked(8'h00, single_result(ST_OK, '0, 1'b0, 1'b0));
		// error code 1
		add_row(8'h08, 1'b0);
		add_checked(8'h01, single_result(ST_BAD_KEY, '0, 1'b0, 1'b0));
		// error code 2 and the largest throttle time
		add_row(8'h08, 1'b0);
		add_row(8'h02, 1'b0);
		add_row(8'h10, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row(8'hFF, 1'b0);
		add_checked(8'h0F, single_result(ST_THROTTLE, 32'hFFFF_FFFF, 1'b0, 1'b0));
		// unknown error code maps to failed
		add_row(8'h08, 1'b0);
		add_checked(8'h7F, single_result(ST_FAILED, '0, 1'b0, 1'b0));
		// bad wire type halts; the trailing byte is ignored
		add_row(8'h0B, 1'b0);
		add_checked(8'hFF, single_result(ST_OK, '0, 1'b0, 1'b1));
		// empty value
		add_row(8'h1A, 1'b0);
		add_checked(8'h00, single_result(ST_OK, '0, 1'b1, 1'b0));
		// two-byte value with extreme bytes
		add_row(8'h1A, 1'b0);
		add_row(8'h02, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'hFF, 1'b1);
		// skip length of MESSAGE_MAX drains the rest
		add_row(8'h22, 1'b0);
		add_row(8'h80, 1'b0);
		add_row(8'h20, 1'b0);
		add_checked(8'h55, single_result(ST_OK, '0, 1'b0, 1'b0));
	endtask

	// Offer one beat, then predict it on acceptance
	task automatic send_beat(input logic [DATA_W-1:0] b, input logic eom, input bit typed,
			input result_t typed_res);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			@(negedge clk);
			byte_ch.valid <= 1'b0;
		end
		@(negedge clk);
		byte_ch.valid          <= 1'b1;
		byte_ch.data_byte      <= b;
		byte_ch.end_of_message <= eom;
		do @(posedge clk); while (!byte_ch.ready);
		beat_results.delete();
		decode_byte(b, eom);
		if (typed) pending_results.push_back(typed_res);
		else foreach (beat_results[i]) pending_results.push_back(beat_results[i]);
	endtask

	// Drop valid and wait for every predicted result
	task automatic drain_results();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic put_varint(input logic [ACC_W-1:0] v);
		int groups;
		int total;
		int i;
		logic [DATA_W-1:0] b;
		groups = 1;
		while (groups < VARINT_MAX_BYTES && (v >> (GROUP_W * groups)) != 0) groups++;
		total = groups;
		// occasionally pad with zero groups
		if ($urandom_range(0, 9) == 0) total = groups + $urandom_range(1, 3);
		if (total > VARINT_MAX_BYTES) total = VARINT_MAX_BYTES;
		for (i = 0; i < total; i++) begin
			b = {(i < total - 1) ? 1'b1 : 1'b0, 7'(v >> (GROUP_W * i))};
			// tenth group: only bit 0 counts, fill the rest with junk
			if (i == VARINT_MAX_BYTES - 1) b[6:1] = 6'($urandom);
			msg_q.push_back(b);
		end
	endtask

	task automatic put_tag(input logic [60:0] fnum, input logic [2:0] wt);
		put_varint({fnum, wt});
	endtask

	task automatic add_payload(input int n);
		repeat (n) msg_q.push_back(8'($urandom));
	endtask

	task automatic add_value_field(input int len);
		put_tag(61'(FC_VALUE), WT_LEN);
		put_varint(64'(len));
		add_payload(len);
	endtask

	function automatic logic [ACC_W-1:0] pick_varint();
		case ($urandom_range(0, 3))
			0: return 64'($urandom_range(0, 3));
			1: return 64'($urandom_range(0, 127));
			2: return 64'($urandom);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [60:0] pick_other_field();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return 61'($urandom_range(4, 15));
			2: return 61'($urandom);
			default: return {29'($urandom_range(1, 7)), 32'($urandom_range(1, 3))};
		endcase
	endfunction

	function automatic int pick_value_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 17) return $urandom_range(0, 6);
		else if (r < 19) return $urandom_range(VALUE_MAX - 2, VALUE_MAX);
		else return $urandom_range(VALUE_MAX + 1, VALUE_MAX + 6);
	endfunction

	task automatic add_random_field();
		int pick;
		int n;
		logic [2:0] wt;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			put_tag(61'(FC_ERROR), WT_VARINT);
			put_varint(pick_varint());
		end else if (pick < 35) begin
			put_tag(61'(FC_THROTTLE), WT_VARINT);
			put_varint(pick_varint());
		end else if (pick < 60) begin
			add_value_field(pick_value_length());
		end else if (pick < 67) begin
			put_tag(61'(FC_VALUE), WT_VARINT);
			put_varint(pick_varint());
		end else if (pick < 74) begin
			// error or throttle sent length-delimited: skipped
			put_tag(61'($urandom_range(1, 2)), WT_LEN);
			n = $urandom_range(0, 3);
			put_varint(64'(n));
			add_payload(n);
		end else if (pick < 84) begin
			if ($urandom_range(0, 1) == 0) begin
				put_tag(pick_other_field(), WT_VARINT);
				put_varint(pick_varint());
			end else begin
				put_tag(pick_other_field(), WT_LEN);
				n = $urandom_range(0, 4);
				put_varint(64'(n));
				add_payload(n);
			end
		end else if (pick < 89) begin
			// skip length at or past the message size
			put_tag(61'($urandom_range(0, 5)), WT_LEN);
			if ($urandom_range(0, 1) == 0) put_varint(64'(MESSAGE_MAX + $urandom_range(0, 200)));
			else put_varint({1'b1, 31'($urandom), $urandom});
			add_payload($urandom_range(0, 3));
		end else if (pick < 95) begin
			do wt = 3'($urandom_range(1, 7)); while (wt == WT_LEN);
			put_tag(61'($urandom_range(0, 5)), wt);
			add_payload($urandom_range(0, 3));
		end else begin
			// varint that never ends within ten bytes
			put_tag(61'(FC_ERROR), WT_VARINT);
			repeat ($urandom_range(10, 11)) msg_q.push_back(8'h80 | 8'($urandom));
		end
	endtask

	task automatic build_random_message();
		int kind;
		int cut;
		msg_q.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			add_payload($urandom_range(1, 6));
		end else begin
			repeat ($urandom_range(1, 4)) add_random_field();
			// cut the message short somewhere
			if (kind == 1) begin
				cut = $urandom_range(1, msg_q.size());
				while (msg_q.size() > cut) void'(msg_q.pop_back());
			end
		end
	endtask

	task automatic send_message();
		foreach (msg_q[i]) send_beat(msg_q[i], i == msg_q.size() - 1, 1'b0, '0);
	endtask

	task automatic compare_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Match one accepted result against the oldest prediction
	task automatic check_result();
		result_t exp_r;
		if (pending_results.size() == 0) begin
			$display("%0t: result with none expected: expected nothing got %0h",
				$time, res_ch.value_byte);
			mismatches++;
		end else begin
			exp_r = pending_results.pop_front();
			compare_field("status_code", 64'(exp_r.status_code), 64'(res_ch.status_code));
			compare_field("throttle_ms", 64'(exp_r.throttle_ms), 64'(res_ch.throttle_ms));
			compare_field("value_present", 64'(exp_r.value_present),
				64'(res_ch.value_present));
			compare_field("value_length", 64'(exp_r.value_length), 64'(res_ch.value_length));
			compare_field("value_byte", 64'(exp_r.value_byte), 64'(res_ch.value_byte));
			compare_field("byte_index", 64'(exp_r.byte_index), 64'(res_ch.byte_index));
			compare_field("value_too_long", 64'(exp_r.value_too_long),
				64'(res_ch.value_too_long));
			compare_field("stopped_early", 64'(exp_r.stopped_early),
				64'(res_ch.stopped_early));
			compare_field("last_result", 64'(exp_r.last_result), 64'(res_ch.last_result));
		end
	endtask

	// Check every accepted result beat
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) check_result();
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** protobuf_read_reply_decoder_top: FAILED **");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					res_ch.ready <= 1'b0;
				end
			end
			stall = no_idle ? 0 : $urandom_range(0, 4);
			repeat (stall) begin
				@(negedge clk);
				res_ch.ready <= 1'b0;
			end
			@(negedge clk);
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready) && !hold_req);
		end
	end

	initial begin : byte_source
		idle_cycles            = 0;
		mismatches             = 0;
		live_beats             = 0;
		no_idle                = 1'b0;
		hold_req               = 1'b0;
		arst_n                 = 1'b0;
		byte_ch.valid          = 1'b0;
		byte_ch.data_byte      = '0;
		byte_ch.end_of_message = 1'b0;
		clear_message();
		pr_bank = 1'b0;
		foreach (value_mem[i]) value_mem[i] = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		build_directed();
		foreach (directed_tab[i])
			send_beat(directed_tab[i].data, directed_tab[i].eom, directed_tab[i].typed,
				directed_tab[i].res);
		drain_results();

		// random messages, first half
		while (live_beats < ITEMS / 2) begin
			no_idle = ($urandom_range(0, 4) == 0);
			build_random_message();
			send_message();
		end

		// hold off the results while long values keep arriving
		hold_req = 1'b1;
		no_idle  = 1'b1;
		repeat (2) begin
			msg_q.delete();
			put_tag(61'(FC_ERROR), WT_VARINT);
			put_varint(64'($urandom_range(0, 3)));
			add_value_field($urandom_range(8, VALUE_MAX));
			send_message();
		end
		no_idle = 1'b0;
		drain_results();

		// random messages, second half
		while (live_beats < ITEMS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			build_random_message();
			send_message();
		end
		no_idle = 1'b0;
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("** protobuf_read_reply_decoder_top: PASSED **");
		else
			$display("** protobuf_read_reply_decoder_top: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rrd_pkg.sv
rtl/core/rrd_if.sv
rtl/core/rrd_parser.sv
rtl/core/rrd_emit.sv
rtl/core/protobuf_read_reply_decoder_top.sv
bench/protobuf_read_reply_decoder_top_test.sv
